@@ design/adbcr_pkg.sv @@
// Shared types and constants for the ADB device command receiver.
// Holds the register indexes, configuration and result structs, reset values and status codes.
// No dependencies.
package adbcr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ATTN_MIN    = 3'd0;
  localparam logic [2:0] REG_ATTN_LIMIT  = 3'd1;
  localparam logic [2:0] REG_CELL_BUDGET = 3'd2;
  localparam logic [2:0] REG_SYNC_WAIT   = 3'd3;
  localparam logic [2:0] REG_SRQ_PULSE   = 3'd4;
  localparam logic [2:0] REG_STOP_WAIT   = 3'd5;

  // reset values of the configuration registers
  localparam logic [9:0] RST_ATTN_MIN    = 10'd500;
  localparam logic [9:0] RST_ATTN_LIMIT  = 10'd1000;
  localparam logic [7:0] RST_CELL_BUDGET = 8'd130;
  localparam logic [7:0] RST_SYNC_WAIT   = 8'd100;
  localparam logic [9:0] RST_SRQ_PULSE   = 10'd250;
  localparam logic [9:0] RST_STOP_WAIT   = 10'd400;

  // frame status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_ATTN     = 2'd1;
  localparam logic [1:0] ST_CELL_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [9:0] attention_min;
    logic [9:0] attention_limit;
    logic [7:0] bit_cell_budget;
    logic [7:0] sync_wait;
    logic [9:0] srq_pulse;
    logic [9:0] stop_wait;
  } adbcr_cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       cmd_valid;
    logic [7:0] command;
    logic [1:0] status;
  } adbcr_result_t;

endpackage

@@ design/adbcr_cfg_regs.sv @@
// Configuration register file of the ADB command receiver.
// Depends on adbcr_pkg for the register indexes, reset values and struct.
module adbcr_cfg_regs
  import adbcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output adbcr_cfg_t  cfg
);

  adbcr_cfg_t cfg_r;

  // always able to take a write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attention_min   <= RST_ATTN_MIN;
      cfg_r.attention_limit <= RST_ATTN_LIMIT;
      cfg_r.bit_cell_budget <= RST_CELL_BUDGET;
      cfg_r.sync_wait       <= RST_SYNC_WAIT;
      cfg_r.srq_pulse       <= RST_SRQ_PULSE;
      cfg_r.stop_wait       <= RST_STOP_WAIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATTN_MIN:    cfg_r.attention_min   <= cfg_data;
        REG_ATTN_LIMIT:  cfg_r.attention_limit <= cfg_data;
        REG_CELL_BUDGET: cfg_r.bit_cell_budget <= cfg_data[7:0];
        REG_SYNC_WAIT:   cfg_r.sync_wait       <= cfg_data[7:0];
        REG_SRQ_PULSE:   cfg_r.srq_pulse       <= cfg_data;
        REG_STOP_WAIT:   cfg_r.stop_wait       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/adbcr_frame_fsm.sv @@
// Per-tick frame decoder: attention, sync, eight bit cells and stop/SRQ.
// Depends on adbcr_pkg for the configuration and result structs.
module adbcr_frame_fsm
  import adbcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          line_level,
  input  logic          service_request,
  input  adbcr_cfg_t    cfg,
  output adbcr_result_t result
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ATTN, PH_SYNC, PH_BITLO, PH_BITHI, PH_STOP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  tick_r, tick_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        srq_r, srq_nxt;

  logic [9:0]  tick_inc;
  logic [9:0]  budget_ext;
  logic [9:0]  hi_ticks;
  logic [3:0]  bit_idx_inc;
  logic        fin;
  logic [7:0]  fin_cmd;
  logic [1:0]  fin_st;
  logic        drive;

  assign tick_inc    = tick_r + 10'd1;
  assign budget_ext  = {2'b00, cfg.bit_cell_budget};
  assign hi_ticks    = tick_r - {2'b00, low_r};
  assign bit_idx_inc = bit_idx_r + 4'd1;

  // next state for one sample; at most two phases are visited per tick
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    low_nxt     = low_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    srq_nxt     = srq_r;
    fin         = 1'b0;
    fin_cmd     = 8'd0;
    fin_st      = ST_OK;
    drive       = 1'b0;

    case (phase_r)
      PH_HUNT: begin
        // falling edge counts as first attention tick
        if (!line_level) begin
          phase_nxt = PH_ATTN;
          tick_nxt  = 10'd1;
          if (cfg.attention_limit <= 10'd1) begin
            fin    = 1'b1;
            fin_st = ST_BAD_ATTN;
          end
        end
      end
      PH_ATTN: begin
        if (!line_level) begin
          tick_nxt = (tick_r == 10'h3FF) ? tick_r : tick_inc;
          if (tick_nxt >= cfg.attention_limit) begin
            fin    = 1'b1;
            fin_st = ST_BAD_ATTN;
          end
        end else if (tick_r >= cfg.attention_min) begin
          // rising tick is first tick of the sync wait
          phase_nxt   = PH_SYNC;
          bit_idx_nxt = 4'd0;
          shift_nxt   = 8'd0;
          tick_nxt    = 10'd1;
          if (cfg.sync_wait <= 8'd1) begin
            phase_nxt = PH_BITLO;
            tick_nxt  = 10'd0;
          end
        end else begin
          fin    = 1'b1;
          fin_st = ST_BAD_ATTN;
        end
      end
      PH_SYNC: begin
        if (!line_level) begin
          phase_nxt = PH_BITLO;
          tick_nxt  = 10'd1;
          if (budget_ext <= 10'd1) begin
            fin    = 1'b1;
            fin_st = ST_CELL_TIMEOUT;
          end
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= {2'b00, cfg.sync_wait}) begin
            phase_nxt = PH_BITLO;
            tick_nxt  = 10'd0;
          end
        end
      end
      PH_BITLO: begin
        // a rise starts the high part and counts in it
        if (line_level) begin
          low_nxt   = tick_r[7:0];
          phase_nxt = PH_BITHI;
        end
        tick_nxt = tick_inc;
        if (tick_inc >= budget_ext) begin
          fin    = 1'b1;
          fin_st = ST_CELL_TIMEOUT;
        end
      end
      PH_BITHI: begin
        if (line_level) begin
          tick_nxt = tick_inc;
          if (tick_inc >= budget_ext) begin
            fin    = 1'b1;
            fin_st = ST_CELL_TIMEOUT;
          end
        end else begin
          // cell done: shift in bit, fall is first tick of next cell or stop
          shift_nxt   = {shift_r[6:0], ({2'b00, low_r} < hi_ticks)};
          bit_idx_nxt = bit_idx_inc;
          low_nxt     = 8'd0;
          tick_nxt    = 10'd1;
          if (bit_idx_inc[3]) begin
            phase_nxt = PH_STOP;
            srq_nxt   = service_request;
            if (service_request) begin
              if (cfg.srq_pulse != 10'd0) begin
                drive = 1'b1;
              end else begin
                fin     = 1'b1;
                fin_cmd = shift_nxt;
              end
            end else if (cfg.stop_wait <= 10'd1) begin
              fin     = 1'b1;
              fin_cmd = shift_nxt;
            end
          end else begin
            phase_nxt = PH_BITLO;
            if (budget_ext <= 10'd1) begin
              fin    = 1'b1;
              fin_st = ST_CELL_TIMEOUT;
            end
          end
        end
      end
      PH_STOP: begin
        if (srq_r) begin
          if (tick_r < cfg.srq_pulse) begin
            drive    = 1'b1;
            tick_nxt = tick_inc;
          end else begin
            fin     = 1'b1;
            fin_cmd = shift_r;
          end
        end else if (line_level) begin
          fin     = 1'b1;
          fin_cmd = shift_r;
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.stop_wait) begin
            fin     = 1'b1;
            fin_cmd = shift_r;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        tick_nxt  = 10'd0;
      end
    endcase

    // frame end clears the whole decoder
    if (fin) begin
      phase_nxt   = PH_HUNT;
      tick_nxt    = 10'd0;
      low_nxt     = 8'd0;
      bit_idx_nxt = 4'd0;
      shift_nxt   = 8'd0;
      srq_nxt     = 1'b0;
    end
  end

  // result of this sample
  always_comb begin
    result.drive_low = drive;
    result.cmd_valid = fin;
    result.command   = fin ? fin_cmd : 8'd0;
    result.status    = fin ? fin_st : ST_OK;
  end

  // decoder state, advanced once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      tick_r    <= 10'd0;
      low_r     <= 8'd0;
      bit_idx_r <= 4'd0;
      shift_r   <= 8'd0;
      srq_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      low_r     <= low_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      srq_r     <= srq_nxt;
    end
  end

endmodule

@@ design/adbcr_out_queue.sv @@
// Two-entry result queue: output register plus skid register.
// Depends on adbcr_pkg for the result struct.
module adbcr_out_queue
  import adbcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adbcr_result_t push_data,
  output logic          space,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output adbcr_result_t head
);

  logic          head_v_r, head_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  adbcr_result_t head_r, head_nxt;
  adbcr_result_t skid_r, skid_nxt;
  logic          pop;

  assign pop       = head_v_r && !out_stall;
  assign space     = !skid_v_r || pop;
  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign head      = head_r;

  // pop moves the skid item forward, push fills the first free slot
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      head_v_nxt = skid_v_r;
      head_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end
    if (push) begin
      if (!head_v_nxt) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ design/adb_command_receiver.sv @@
// ADB device command receiver. Each input item is one sample of the bus data
// line taken on a microsecond tick, together with the service-request flag;
// each item yields exactly one result item (drive_low, cmd_valid, command,
// status). The block takes one item per clock cycle while the output queue has
// room and runs back to back: a sample passes an input register, the frame
// decoder works on it combinationally from its registered phase and counters,
// and the result enters a two-entry output queue whose head register offers
// it; a full queue holds samples in the input register. The rate is set by
// the loop through the decoder's phase and tick counter.
// in_stall rises only when the output queue is full and out_stall is held.
// Configuration writes are accepted every cycle and take effect for the next
// sample; write them only while the block is idle.
module adb_command_receiver
  import adbcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // sample items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_line_level,
  input  logic       in_service_request,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_drive_low,
  output logic       out_cmd_valid,
  output logic [7:0] out_command,
  output logic [1:0] out_status,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  logic          stage_v_r;
  logic          line_r;
  logic          srq_r;
  logic          q_space;
  logic          q_full;
  logic          step;
  adbcr_cfg_t    cfg;
  adbcr_result_t res;
  adbcr_result_t head;

  // stage fires into the queue when there is room
  assign step     = stage_v_r && q_space;
  assign in_stall = stage_v_r && !q_space;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (!in_stall) begin
      stage_v_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      line_r <= in_line_level;
      srq_r  <= in_service_request;
    end
  end

  adbcr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adbcr_frame_fsm u_fsm (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .line_level      (line_r),
    .service_request (srq_r),
    .cfg             (cfg),
    .result          (res)
  );

  adbcr_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .space     (q_space),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_drive_low = head.drive_low;
  assign out_cmd_valid = head.cmd_valid;
  assign out_command   = head.command;
  assign out_status    = head.status;

  // a stall on the input only ever comes from a held item in the stage
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_v_r)
    else $error("input stalled with empty stage");

  // a full queue always offers its head item
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> out_valid)
    else $error("skid entry held without head entry");

  // the line is never driven on the tick a frame is reported
  a_drive_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.drive_low |-> !res.cmd_valid)
    else $error("drive_low together with frame end");

  // no frame end means zero command and ok status
  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step && !res.cmd_valid |-> (res.command == 8'd0) && (res.status == ST_OK))
    else $error("nonzero command or status without frame end");

endmodule
